/* sv/dtw_pkg.sv */
// Shared types, codes and widths of the dynamic time warping unit.
package dtw_pkg;

   localparam int IDX_W      = 5;
   localparam int CNT_W      = 6;
   localparam int VAL_W      = 16;
   localparam int SQ_W       = 32;
   localparam int COST_W     = 38;
   localparam int DIVD_W     = COST_W + 8;
   localparam int AVG_W      = 40;
   localparam int CELL_DEPTH = 1024;
   localparam int PATH_DEPTH = 64;
   localparam int PATH_W     = 2 * IDX_W;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] csel_type;

   localparam kind_type KIND_SAMPLE   = 2'd0;
   localparam kind_type KIND_TEMPLATE = 2'd1;
   localparam kind_type KIND_RUN      = 2'd2;
   localparam kind_type KIND_UNUSED   = 2'd3;

   localparam status_type STAT_OK      = 2'd0;
   localparam status_type STAT_EMPTY   = 2'd1;
   localparam status_type STAT_DROPPED = 2'd2;

   localparam csel_type CSEL_UP   = 2'd0;
   localparam csel_type CSEL_LEFT = 2'd1;
   localparam csel_type CSEL_DIAG = 2'd2;

   typedef struct packed {
      logic     req_ready;
      csel_type csel;
      logic     fill_dif;
      logic     fill_sq;
      logic     fill_wr;
      logic     bt_wr;
      logic     bt_up;
      logic     bt_left;
      logic     bt_move;
      logic     div_start;
      logic     out_init;
      logic     out_load;
      logic     err_load;
   } cmd_type;

   typedef struct packed {
      logic run_acc;
      logic empty;
      logic fill_last;
      logic i_zero;
      logic j_zero;
      logic div_done;
      logic out_last;
      logic slot_free;
   } sts_type;

endpackage

/* sv/dtw_if.sv */
// Valid/ready channel interfaces for the request and response items.
interface dtw_req_if;
   import dtw_pkg::*;
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic signed [VAL_W-1:0] value;
   modport source (output valid, kind, value, input ready);
   modport sink (input valid, kind, value, output ready);
endinterface

interface dtw_rsp_if;
   import dtw_pkg::*;
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  sample_index;
   logic [IDX_W-1:0]  template_index;
   logic              last;
   status_type        status;
   logic [COST_W-1:0] total_cost;
   logic [CNT_W-1:0]  path_length;
   logic [AVG_W-1:0]  average_cost;
   modport source (output valid, sample_index, template_index, last, status, total_cost,
                   path_length, average_cost, input ready);
   modport sink (input valid, sample_index, template_index, last, status, total_cost,
                 path_length, average_cost, output ready);
endinterface

/* sv/dtw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dtw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/dtw_div.sv */
// Restoring divider, one quotient bit per cycle, for the average cost.
module dtw_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [dtw_pkg::DIVD_W-1:0] dividend,
   input  logic [dtw_pkg::CNT_W-1:0]  divisor,
   output logic [dtw_pkg::DIVD_W-1:0] quotient,
   output logic                       done
);
   import dtw_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIVD_W-1:0] q_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  d_ff;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_sub;

   assign rem_sh  = {rem_ff, q_ff[DIVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, d_ff}) begin
            rem_ff <= rem_sub[CNT_W-1:0];
            q_ff   <= {q_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[CNT_W-1:0];
            q_ff   <= {q_ff[DIVD_W-2:0], 1'b0};
         end
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;
endmodule

/* sv/dtw_dp.sv */
// Datapath: sequence stores, cost matrix fill, backtrack, divider and output register.
module dtw_dp #(
   parameter int MAX_SAMPLE_LEN   = 32,
   parameter int MAX_TEMPLATE_LEN = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dtw_pkg::cmd_type            cmd,
   output dtw_pkg::sts_type            sts,
   input  logic                        req_acc,
   input  dtw_pkg::kind_type           req_kind,
   input  logic signed [15:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dtw_pkg::IDX_W-1:0]   rsp_sample_index,
   output logic [dtw_pkg::IDX_W-1:0]   rsp_template_index,
   output logic                        rsp_last,
   output dtw_pkg::status_type         rsp_status,
   output logic [dtw_pkg::COST_W-1:0]  rsp_total_cost,
   output logic [dtw_pkg::CNT_W-1:0]   rsp_path_length,
   output logic [dtw_pkg::AVG_W-1:0]   rsp_average_cost
);
   import dtw_pkg::*;

   localparam int SAW = (MAX_SAMPLE_LEN > 1) ? $clog2(MAX_SAMPLE_LEN) : 1;
   localparam int TAW = (MAX_TEMPLATE_LEN > 1) ? $clog2(MAX_TEMPLATE_LEN) : 1;
   localparam int CAW = $clog2(CELL_DEPTH);
   localparam int PAW = $clog2(PATH_DEPTH);

   logic [CNT_W-1:0]  s_cnt_ff, t_cnt_ff, n_ff, m_ff, k_ff, r_ff;
   logic              ovf_ff;
   status_type        status_ff;
   logic [IDX_W-1:0]  i_ff, j_ff;
   logic signed [VAL_W:0] diff_ff;
   logic [SQ_W-1:0]   sq_ff;
   logic [COST_W-1:0] up_ff, diag_ff, left_ff, best_ff, total_ff;

   logic                  s_wr, t_wr;
   logic [VAL_W-1:0]      s_rdata, t_rdata;
   logic [COST_W-1:0]     cost_rdata, cell_sum, best_in, min_ud, bt_min;
   logic [CAW-1:0]        cost_raddr;
   logic [IDX_W-1:0]      i_dec, j_dec;
   logic signed [2*VAL_W+1:0] prod;
   logic [PATH_W-1:0]     path_rdata;
   logic [PAW-1:0]        path_raddr;
   logic [DIVD_W-1:0]     quot;
   logic                  rsp_valid_ff, slot_free;
   logic                  left_lt, diag_lt;

   assign s_wr = req_acc && req_kind == KIND_SAMPLE && s_cnt_ff < CNT_W'(MAX_SAMPLE_LEN);
   assign t_wr = req_acc && req_kind == KIND_TEMPLATE && t_cnt_ff < CNT_W'(MAX_TEMPLATE_LEN);

   dtw_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SAMPLE_LEN)) u_sample_ram (
      .clock(clock), .wr_en(s_wr), .wr_addr(s_cnt_ff[SAW-1:0]), .wr_data(req_value),
      .rd_addr(i_ff[SAW-1:0]), .rd_data(s_rdata));

   dtw_ram #(.WIDTH(VAL_W), .DEPTH(MAX_TEMPLATE_LEN)) u_template_ram (
      .clock(clock), .wr_en(t_wr), .wr_addr(t_cnt_ff[TAW-1:0]), .wr_data(req_value),
      .rd_addr(j_ff[TAW-1:0]), .rd_data(t_rdata));

   assign i_dec = i_ff - 1'b1;
   assign j_dec = j_ff - 1'b1;

   always_comb begin
      unique case (cmd.csel)
         CSEL_LEFT: cost_raddr = {i_ff, j_dec};
         CSEL_DIAG: cost_raddr = {i_dec, j_dec};
         default:   cost_raddr = {i_dec, j_ff};
      endcase
   end

   assign cell_sum = best_ff + COST_W'(sq_ff);

   dtw_ram #(.WIDTH(COST_W), .DEPTH(CELL_DEPTH)) u_cost_ram (
      .clock(clock), .wr_en(cmd.fill_wr), .wr_addr({i_ff, j_ff}), .wr_data(cell_sum),
      .rd_addr(cost_raddr), .rd_data(cost_rdata));

   assign path_raddr = PAW'(k_ff - r_ff - 1'b1);

   dtw_ram #(.WIDTH(PATH_W), .DEPTH(PATH_DEPTH)) u_path_ram (
      .clock(clock), .wr_en(cmd.bt_wr), .wr_addr(k_ff), .wr_data({i_ff, j_ff}),
      .rd_addr(path_raddr), .rd_data(path_rdata));

   dtw_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend({total_ff, 8'd0}),
      .divisor(k_ff), .quotient(quot), .done(sts.div_done));

   assign prod = diff_ff * diff_ff;

   // Edge cells take their one neighbor (the origin none); inner cells the smallest of three.
   always_comb begin
      min_ud = (diag_ff < up_ff) ? diag_ff : up_ff;
      if (i_ff == '0 && j_ff == '0) begin
         best_in = '0;
      end else if (i_ff == '0) begin
         best_in = left_ff;
      end else if (j_ff == '0) begin
         best_in = up_ff;
      end else begin
         best_in = (left_ff < min_ud) ? left_ff : min_ud;
      end
   end

   // Backtrack preference is up, then left, then diagonal; only a strictly smaller one wins.
   assign left_lt = left_ff < up_ff;
   assign bt_min  = left_lt ? left_ff : up_ff;
   assign diag_lt = cost_rdata < bt_min;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_cnt_ff <= '0;
         t_cnt_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (req_acc) begin
         unique case (req_kind)
            KIND_SAMPLE: begin
               if (s_wr) s_cnt_ff <= s_cnt_ff + 1'b1;
               else ovf_ff <= 1'b1;
            end
            KIND_TEMPLATE: begin
               if (t_wr) t_cnt_ff <= t_cnt_ff + 1'b1;
               else ovf_ff <= 1'b1;
            end
            KIND_RUN: begin
               s_cnt_ff <= '0;
               t_cnt_ff <= '0;
               ovf_ff   <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_kind == KIND_RUN) begin
         n_ff      <= s_cnt_ff;
         m_ff      <= t_cnt_ff;
         status_ff <= ovf_ff ? STAT_DROPPED : STAT_OK;
         i_ff      <= '0;
         j_ff      <= '0;
      end
      if (cmd.fill_dif) begin
         diff_ff <= {s_rdata[VAL_W-1], s_rdata} - {t_rdata[VAL_W-1], t_rdata};
         up_ff   <= cost_rdata;
      end
      if (cmd.fill_sq) begin
         sq_ff   <= prod[SQ_W-1:0];
         best_ff <= best_in;
      end
      if (cmd.fill_wr) begin
         left_ff  <= cell_sum;
         diag_ff  <= up_ff;
         total_ff <= cell_sum;
         k_ff     <= '0;
         if (!sts.fill_last) begin
            if (j_ff == IDX_W'(m_ff - 1'b1)) begin
               j_ff <= '0;
               i_ff <= i_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
      end
      if (cmd.bt_wr) begin
         k_ff <= k_ff + 1'b1;
         if (i_ff == '0 && j_ff != '0) begin
            j_ff <= j_dec;
         end else if (j_ff == '0 && i_ff != '0) begin
            i_ff <= i_dec;
         end
      end
      if (cmd.bt_up) up_ff <= cost_rdata;
      if (cmd.bt_left) left_ff <= cost_rdata;
      if (cmd.bt_move) begin
         if (diag_lt) begin
            i_ff <= i_dec;
            j_ff <= j_dec;
         end else if (left_lt) begin
            j_ff <= j_dec;
         end else begin
            i_ff <= i_dec;
         end
      end
      if (cmd.out_init) r_ff <= '0;
      else if (cmd.out_load) r_ff <= r_ff + 1'b1;
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.err_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_sample_index   <= path_rdata[PATH_W-1:IDX_W];
         rsp_template_index <= path_rdata[IDX_W-1:0];
         rsp_last           <= sts.out_last;
         rsp_status         <= status_ff;
         rsp_total_cost     <= sts.out_last ? total_ff : '0;
         rsp_path_length    <= sts.out_last ? k_ff : '0;
         rsp_average_cost   <= sts.out_last ? quot[AVG_W-1:0] : '0;
      end else if (cmd.err_load) begin
         rsp_sample_index   <= '0;
         rsp_template_index <= '0;
         rsp_last           <= 1'b1;
         rsp_status         <= STAT_EMPTY;
         rsp_total_cost     <= '0;
         rsp_path_length    <= '0;
         rsp_average_cost   <= '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign sts.run_acc   = req_acc && req_kind == KIND_RUN;
   assign sts.empty     = n_ff == '0 || m_ff == '0;
   assign sts.fill_last = i_ff == IDX_W'(n_ff - 1'b1) && j_ff == IDX_W'(m_ff - 1'b1);
   assign sts.i_zero    = i_ff == '0;
   assign sts.j_zero    = j_ff == '0;
   assign sts.out_last  = r_ff == k_ff - 1'b1;
   assign sts.slot_free = slot_free;
endmodule

/* sv/dtw_ctrl.sv */
// Controller state machine that sequences fill, backtrack, division and output.
module dtw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  dtw_pkg::sts_type sts,
   output dtw_pkg::cmd_type cmd
);
   import dtw_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_CHK  = 4'd1;
   localparam logic [3:0] S_FRD  = 4'd2;
   localparam logic [3:0] S_FDIF = 4'd3;
   localparam logic [3:0] S_FSQ  = 4'd4;
   localparam logic [3:0] S_FWR  = 4'd5;
   localparam logic [3:0] S_BWR  = 4'd6;
   localparam logic [3:0] S_BRU  = 4'd7;
   localparam logic [3:0] S_BRL  = 4'd8;
   localparam logic [3:0] S_BRD  = 4'd9;
   localparam logic [3:0] S_BMV  = 4'd10;
   localparam logic [3:0] S_DS   = 4'd11;
   localparam logic [3:0] S_DW   = 4'd12;
   localparam logic [3:0] S_ORD  = 4'd13;
   localparam logic [3:0] S_OSH  = 4'd14;
   localparam logic [3:0] S_EOUT = 4'd15;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.csel = CSEL_UP;
      unique case (state_ff)
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.run_acc) state_in = S_CHK;
         end
         S_CHK:  state_in = sts.empty ? S_EOUT : S_FRD;
         S_FRD:  state_in = S_FDIF;
         S_FDIF: begin
            cmd.fill_dif = 1'b1;
            state_in     = S_FSQ;
         end
         S_FSQ: begin
            cmd.fill_sq = 1'b1;
            state_in    = S_FWR;
         end
         S_FWR: begin
            cmd.fill_wr = 1'b1;
            state_in    = sts.fill_last ? S_BWR : S_FRD;
         end
         S_BWR: begin
            cmd.bt_wr = 1'b1;
            if (sts.i_zero && sts.j_zero) state_in = S_DS;
            else if (sts.i_zero || sts.j_zero) state_in = S_BWR;
            else state_in = S_BRU;
         end
         S_BRU: state_in = S_BRL;
         S_BRL: begin
            cmd.csel   = CSEL_LEFT;
            cmd.bt_up  = 1'b1;
            state_in   = S_BRD;
         end
         S_BRD: begin
            cmd.csel    = CSEL_DIAG;
            cmd.bt_left = 1'b1;
            state_in    = S_BMV;
         end
         S_BMV: begin
            cmd.bt_move = 1'b1;
            state_in    = S_BWR;
         end
         S_DS: begin
            cmd.div_start = 1'b1;
            cmd.out_init  = 1'b1;
            state_in      = S_DW;
         end
         S_DW:  if (sts.div_done) state_in = S_ORD;
         S_ORD: state_in = S_OSH;
         S_OSH: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.out_last ? S_IDLE : S_ORD;
            end
         end
         S_EOUT: begin
            if (sts.slot_free) begin
               cmd.err_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

/* sv/dtw_distance_and_path_unit.sv */
// Top level of the dynamic time warping unit: distance and warping path.
//
//   Channel   Direction  Item
//   req_chan  in         kind (load sample, load template, run) and a 16-bit element
//   rsp_chan  out        one warping path point; the last one carries cost, length, average
//
// A run fills each matrix cell in read, difference, square and write states (one cost RAM
// read port), reads the up, left and diagonal costs only at inner points of the backtrack,
// runs the bit-serial divider and then emits each path point when the output slot is free.
// Reset is synchronous and clears the counts and control; no RAM clearing is needed.
// Loads are taken while the last point of a run still waits in the output register.
module dtw_distance_and_path_unit #(
   parameter int MAX_SAMPLE_LEN   = 32,
   parameter int MAX_TEMPLATE_LEN = 32
) (
   input logic       clock,
   input logic       reset,
   dtw_req_if.sink   req_chan,
   dtw_rsp_if.source rsp_chan
);
   import dtw_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    req_acc;

   assign req_chan.ready = cmd.req_ready;
   assign req_acc        = req_chan.valid && cmd.req_ready;

   dtw_ctrl u_ctrl (.clock(clock), .reset(reset), .sts(sts), .cmd(cmd));

   dtw_dp #(.MAX_SAMPLE_LEN(MAX_SAMPLE_LEN), .MAX_TEMPLATE_LEN(MAX_TEMPLATE_LEN)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_acc(req_acc), .req_kind(req_chan.kind), .req_value(req_chan.value),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_sample_index(rsp_chan.sample_index), .rsp_template_index(rsp_chan.template_index),
      .rsp_last(rsp_chan.last), .rsp_status(rsp_chan.status),
      .rsp_total_cost(rsp_chan.total_cost), .rsp_path_length(rsp_chan.path_length),
      .rsp_average_cost(rsp_chan.average_cost));
endmodule
